@@ hw/rtl/polygon_convexity_checker_macros.svh @@
// assertion macros for the polygon convexity checker
// no dependencies; included by the files that carry assertions
`ifndef POLYGON_CONVEXITY_CHECKER_MACROS_SVH
`define POLYGON_CONVEXITY_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcc: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define PCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcc: next-cycle check failed");

`endif

@@ hw/rtl/pcc_pkg.sv @@
// shared types and constants of the polygon convexity checker
// no dependencies
package pcc_pkg;

    localparam int EPS_W   = 16;
    localparam int PDATA_W = 32;
    localparam int ADDR_W  = 2;

    localparam logic [EPS_W-1:0]  EPS_RESET    = 16'd66;
    localparam logic [ADDR_W-1:0] ADDR_EPSILON = 2'd0;

    // per-vertex control carried down the turn pipeline
    typedef struct packed {
        logic last;
        logic int_en;
        logic close_en;
    } t_ctl;

endpackage

@@ hw/rtl/polygon_convexity_checker.sv @@
// polygon convexity checker: vertex stream in, one convex flag per polygon out
// depends on pcc_pkg and polygon_convexity_checker_macros.svh

// Takes one vertex per cycle while o_ready is high (i_valid/o_ready) and
// reports one convex flag per polygon after the vertex marked i_last
// (o_valid/i_ready). After the last vertex is accepted its turns pass through a
// difference register, a product register holding six parallel signed
// multiplies, and the compare with epsilon into the output register. The
// output register lets the next polygon's vertices keep flowing while a result
// waits. Polygons of fewer than three vertices report convex. epsilon lives at
// byte address 0 of the APB port.
`include "polygon_convexity_checker_macros.svh"

module polygon_convexity_checker #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_WIDTH-1:0]     i_x,
    input  logic signed [COORD_WIDTH-1:0]     i_y,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_convex,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcc_pkg::ADDR_W-1:0]        paddr,
    input  logic [pcc_pkg::PDATA_W-1:0]       pwdata,
    output logic [pcc_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import pcc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // configuration
    logic [EPS_W-1:0] r_eps;

    // polygon tracking state
    logic [1:0]           r_vcount;
    logic [1:0]           n_vcount;
    logic signed [CW-1:0] r_first_x, r_first_y, r_second_x, r_second_y;
    logic signed [CW-1:0] r_prev_x, r_prev_y, r_bprev_x, r_bprev_y;

    // stage 1: edge differences
    logic                 r_s1_valid;
    t_ctl                 r_s1_ctl;
    logic signed [DW-1:0] r_dax, r_day, r_dbx, r_dby, r_dcx, r_dcy, r_ddx, r_ddy;

    // stage 2: products
    logic                 r_s2_valid;
    t_ctl                 r_s2_ctl;
    logic signed [PW-1:0] r_p [3];
    logic signed [PW-1:0] r_q [3];

    // stage 3: sign flags and output register
    logic r_seen_pos, r_seen_neg;
    logic r_o_valid;
    logic r_convex;

    logic w_in_acc, w_adv2, w_adv3, w_take1, w_take2;
    logic w_cfg_wr;
    logic signed [DW-1:0] w_cur_x, w_cur_y, w_prev_x, w_prev_y, w_bprev_x, w_bprev_y;
    logic signed [DW-1:0] w_first_x, w_first_y, w_second_x, w_second_y;
    logic [2:0] w_en, w_turn_pos, w_turn_neg;
    logic       w_pos_all, w_neg_all;
    logic signed [SW-1:0] w_eps;
    t_ctl       w_ctl;

    // flow control: a stage moves when the one after it is free or moving
    assign w_adv3  = r_s2_valid && (!r_s2_ctl.last || !r_o_valid || i_ready);
    assign w_take2 = !r_s2_valid || w_adv3;
    assign w_adv2  = r_s1_valid && w_take2;
    assign w_take1 = !r_s1_valid || w_adv2;
    assign o_ready = w_take1;
    assign w_in_acc = i_valid && w_take1;

    // apb port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_EPSILON);
    assign prdata   = (paddr == ADDR_EPSILON) ? PDATA_W'(r_eps) : '0;

    // sign-extended coordinates
    assign w_cur_x    = {i_x[CW-1], i_x};
    assign w_cur_y    = {i_y[CW-1], i_y};
    assign w_prev_x   = {r_prev_x[CW-1], r_prev_x};
    assign w_prev_y   = {r_prev_y[CW-1], r_prev_y};
    assign w_bprev_x  = {r_bprev_x[CW-1], r_bprev_x};
    assign w_bprev_y  = {r_bprev_y[CW-1], r_bprev_y};
    assign w_first_x  = {r_first_x[CW-1], r_first_x};
    assign w_first_y  = {r_first_y[CW-1], r_first_y};
    assign w_second_x = {r_second_x[CW-1], r_second_x};
    assign w_second_y = {r_second_y[CW-1], r_second_y};

    // two or more earlier vertices: interior turn, and closing turns on last
    always_comb begin
        w_ctl.last     = i_last;
        w_ctl.int_en   = r_vcount[1];
        w_ctl.close_en = i_last && r_vcount[1];
        if (i_last) begin
            n_vcount = 2'd0;
        end else if (r_vcount != 2'd3) begin
            n_vcount = r_vcount + 2'd1;
        end else begin
            n_vcount = r_vcount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps      <= EPS_RESET;
            r_vcount   <= 2'd0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_seen_pos <= 1'b0;
            r_seen_neg <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_eps <= pwdata[EPS_W-1:0];
            end
            if (w_in_acc) begin
                r_vcount <= n_vcount;
            end
            if (w_take1) begin
                r_s1_valid <= w_in_acc;
            end
            if (w_take2) begin
                r_s2_valid <= w_adv2;
            end
            if (w_adv3) begin
                if (r_s2_ctl.last) begin
                    r_seen_pos <= 1'b0;
                    r_seen_neg <= 1'b0;
                end else begin
                    r_seen_pos <= w_pos_all;
                    r_seen_neg <= w_neg_all;
                end
            end
            if (w_adv3 && r_s2_ctl.last) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // vertex history and stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (r_vcount == 2'd0) begin
                r_first_x <= i_x;
                r_first_y <= i_y;
            end
            if (r_vcount == 2'd1) begin
                r_second_x <= i_x;
                r_second_y <= i_y;
            end
            r_bprev_x <= r_prev_x;
            r_bprev_y <= r_prev_y;
            r_prev_x  <= i_x;
            r_prev_y  <= i_y;

            r_s1_ctl <= w_ctl;
            r_dax    <= w_prev_x - w_bprev_x;
            r_day    <= w_prev_y - w_bprev_y;
            r_dbx    <= w_cur_x - w_prev_x;
            r_dby    <= w_cur_y - w_prev_y;
            r_dcx    <= w_first_x - w_cur_x;
            r_dcy    <= w_first_y - w_cur_y;
            r_ddx    <= w_second_x - w_first_x;
            r_ddy    <= w_second_y - w_first_y;
        end
    end

    // stage 2: turn at previous vertex, at the last vertex and at the first vertex
    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_ctl <= r_s1_ctl;
            r_p[0]   <= r_dax * r_dby;
            r_q[0]   <= r_day * r_dbx;
            r_p[1]   <= r_dbx * r_dcy;
            r_q[1]   <= r_dby * r_dcx;
            r_p[2]   <= r_dcx * r_ddy;
            r_q[2]   <= r_dcy * r_ddx;
        end
    end

    // stage 3: dead-band compare, cross = p - q against +/- epsilon
    assign w_eps = SW'(r_eps);
    assign w_en  = {r_s2_ctl.close_en, r_s2_ctl.close_en, r_s2_ctl.int_en};

    always_comb begin
        logic signed [SW-1:0] p_ext;
        logic signed [SW-1:0] q_ext;
        for (int i = 0; i < 3; i++) begin
            p_ext = {r_p[i][PW-1], r_p[i]};
            q_ext = {r_q[i][PW-1], r_q[i]};
            w_turn_pos[i] = w_en[i] && (p_ext > q_ext + w_eps);
            w_turn_neg[i] = w_en[i] && (p_ext + w_eps < q_ext);
        end
        w_pos_all = r_seen_pos || (|w_turn_pos);
        w_neg_all = r_seen_neg || (|w_turn_neg);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && r_s2_ctl.last) begin
            r_convex <= !(w_pos_all && w_neg_all);
        end
    end

    assign o_valid  = r_o_valid;
    assign o_convex = r_convex;

    `PCC_ASSERT_NXT(a_count_clears, i_clk, i_rst_n, w_in_acc && i_last, r_vcount == 2'd0)
    `PCC_ASSERT_IMP(a_close_only_on_last, i_clk, i_rst_n, r_s1_valid && r_s1_ctl.close_en, r_s1_ctl.int_en && r_s1_ctl.last)
    `PCC_ASSERT_NXT(a_s2_held, i_clk, i_rst_n, r_s2_valid && !w_adv3, r_s2_valid)
    `PCC_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, w_adv3 && r_s2_ctl.last, r_o_valid)

endmodule
